FILE: rtl/rbe_pkg.sv
`default_nettype none

package rbe_pkg;

    localparam int STATE_W       = 32;
    localparam int STATE_LOW_EXP = 23;
    localparam logic [STATE_W-1:0] STATE_RESET = STATE_W'(1) << STATE_LOW_EXP;

    localparam int PB_W = 5;
    localparam logic [PB_W-1:0] PB_RESET = 5'd12;
    localparam logic [PB_W-1:0] PB_MIN   = 5'd1;
    localparam logic [PB_W-1:0] PB_MAX   = 5'd16;
    // shift that turns freq into the renormalisation limit: 23 - pb + 8
    localparam logic [PB_W-1:0] XMAX_SHIFT_BASE = PB_W'(STATE_LOW_EXP + 8);

    localparam int START_W = 16;
    localparam int FREQ_W  = 17;
    localparam int BYTE_W  = 8;
    localparam int SUM_W   = FREQ_W + 1;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TUSER_W = 2;
    localparam int USER_FLUSH  = 0;
    localparam int USER_ERR    = 1;

    localparam logic KIND_FLUSH = 1'b1;

    // radix-16 divider: four quotient bits per cycle
    localparam int DIV_BITS_PER_STEP = 4;
    localparam int DIV_STEPS         = STATE_W / DIV_BITS_PER_STEP;
    localparam int CNT_W             = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] FLUSH_LAST = CNT_W'(STATE_W / BYTE_W - 1);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        CMD_ENC,
        CMD_FLUSH,
        CMD_ERR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [START_W-1:0]     start;
        logic [FREQ_W-1:0]      freq;
        logic [STATE_W-1:0]     x_max;
    } cmd_t;

    function automatic logic [PB_W-1:0] clamp_pb(input logic [PB_W-1:0] pb);
        logic [PB_W-1:0] r;
        if (pb < PB_MIN) begin
            r = PB_MIN;
        end else if (pb > PB_MAX) begin
            r = PB_MAX;
        end else begin
            r = pb;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rbe_front.sv
`default_nettype none

module rbe_front (
    input  wire logic [rbe_pkg::PB_W-1:0]       pb,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [rbe_pkg::IN_TDATA_W-1:0] s_tdata,   // sym_start, sym_freq, zero pad
    input  wire logic                           s_tuser,   // kind
    output logic                                q_push,
    output rbe_pkg::cmd_t                       q_data,
    input  wire logic                           q_full
);

    logic [rbe_pkg::START_W-1:0] start;
    logic [rbe_pkg::FREQ_W-1:0]  freq;
    logic [rbe_pkg::SUM_W-1:0]   total;
    logic [rbe_pkg::SUM_W-1:0]   sum;
    logic                        bad;

    assign start = s_tdata[rbe_pkg::START_W-1:0];
    assign freq  = s_tdata[rbe_pkg::START_W+rbe_pkg::FREQ_W-1:rbe_pkg::START_W];
    assign total = rbe_pkg::SUM_W'(1) << pb;
    assign sum   = rbe_pkg::SUM_W'(start) + rbe_pkg::SUM_W'(freq);
    assign bad   = (freq == '0) || (sum > total);

    always_comb begin
        q_data.start = start;
        q_data.freq  = freq;
        q_data.x_max = rbe_pkg::STATE_W'(freq) << (rbe_pkg::XMAX_SHIFT_BASE - pb);
        if (s_tuser == rbe_pkg::KIND_FLUSH) begin
            q_data.kind = rbe_pkg::CMD_FLUSH;
        end else if (bad) begin
            q_data.kind = rbe_pkg::CMD_ERR;
        end else begin
            q_data.kind = rbe_pkg::CMD_ENC;
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

`default_nettype wire

FILE: rtl/rbe_queue.sv
`default_nettype none

module rbe_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire rbe_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output rbe_pkg::cmd_t      pop_data,
    output logic               not_empty
);

    rbe_pkg::cmd_t                mem_reg [rbe_pkg::QDEPTH];
    logic [rbe_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [rbe_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [rbe_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                         do_push, do_pop;

    assign full      = (count_reg == rbe_pkg::QCNT_W'(rbe_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == rbe_pkg::QPTR_W'(rbe_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == rbe_pkg::QPTR_W'(rbe_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rbe_back.sv
`default_nettype none

module rbe_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [rbe_pkg::PB_W-1:0]        pb,
    input  wire logic                            cmd_valid,
    input  wire rbe_pkg::cmd_t                   cmd_in,
    output logic                                 cmd_pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [rbe_pkg::BYTE_W-1:0]           m_tdata,   // out_byte
    output logic [rbe_pkg::OUT_TUSER_W-1:0]      m_tuser,   // is_flush, error
    output logic                                 m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RENORM,
        ST_DIV,
        ST_FOLD,
        ST_FLUSH,
        ST_ERR
    } state_t;

    state_t                          state_reg, state_next;
    rbe_pkg::cmd_t                   cmd_reg, cmd_next;
    logic [rbe_pkg::STATE_W-1:0]     st_reg, st_next;
    logic [rbe_pkg::STATE_W-1:0]     dq_reg, dq_next;
    logic [rbe_pkg::FREQ_W-1:0]      rem_reg, rem_next;
    logic [rbe_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                            out_valid_reg, out_valid_next;
    logic [rbe_pkg::BYTE_W-1:0]      out_byte_reg, out_byte_next;
    logic                            out_flush_reg, out_flush_next;
    logic                            out_last_reg, out_last_next;
    logic                            out_err_reg, out_err_next;

    logic                            load_ok;
    logic [rbe_pkg::STATE_W-1:0]     st_shr;
    logic [rbe_pkg::STATE_W-1:0]     div_dq;
    logic [rbe_pkg::FREQ_W-1:0]      div_rem;

    assign load_ok = !out_valid_reg || m_tready;
    assign st_shr  = st_reg >> rbe_pkg::BYTE_W;

    // four restoring steps of the radix-16 divider
    always_comb begin
        logic [rbe_pkg::SUM_W-1:0]   t;
        logic [rbe_pkg::FREQ_W-1:0]  r;
        logic [rbe_pkg::STATE_W-1:0] d;
        r = rem_reg;
        d = dq_reg;
        for (int j = 0; j < rbe_pkg::DIV_BITS_PER_STEP; j++) begin
            t = {r, d[rbe_pkg::STATE_W-1]};
            d = d << 1;
            if (t >= rbe_pkg::SUM_W'(cmd_reg.freq)) begin
                t    = t - rbe_pkg::SUM_W'(cmd_reg.freq);
                d[0] = 1'b1;
            end
            r = t[rbe_pkg::FREQ_W-1:0];
        end
        div_dq  = d;
        div_rem = r;
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        st_next        = st_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_flush_next = out_flush_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        cmd_pop        = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd_in;
                    cnt_next = '0;
                    case (cmd_in.kind)
                        rbe_pkg::CMD_FLUSH: state_next = ST_FLUSH;
                        rbe_pkg::CMD_ERR:   state_next = ST_ERR;
                        default:            state_next = ST_RENORM;
                    endcase
                end
            end
            ST_RENORM: begin
                if (st_reg >= cmd_reg.x_max) begin
                    if (load_ok) begin
                        out_valid_next = 1'b1;
                        out_byte_next  = st_reg[rbe_pkg::BYTE_W-1:0];
                        out_flush_next = 1'b0;
                        out_last_next  = (st_shr < cmd_reg.x_max);
                        out_err_next   = 1'b0;
                        st_next        = st_shr;
                    end
                end else begin
                    dq_next    = st_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                dq_next  = div_dq;
                rem_next = div_rem;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == rbe_pkg::DIV_LAST) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                st_next = (dq_reg << pb) + rbe_pkg::STATE_W'(rem_reg)
                        + rbe_pkg::STATE_W'(cmd_reg.start);
                state_next = ST_IDLE;
            end
            ST_FLUSH: begin
                if (load_ok) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = st_reg[rbe_pkg::STATE_W-1 -: rbe_pkg::BYTE_W];
                    out_flush_next = 1'b1;
                    out_last_next  = (cnt_reg == rbe_pkg::FLUSH_LAST);
                    out_err_next   = 1'b0;
                    st_next        = st_reg << rbe_pkg::BYTE_W;
                    cnt_next       = cnt_reg + 1'b1;
                    if (cnt_reg == rbe_pkg::FLUSH_LAST) begin
                        st_next    = rbe_pkg::STATE_RESET;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR: begin
                if (load_ok) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = '0;
                    out_flush_next = 1'b0;
                    out_last_next  = 1'b1;
                    out_err_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            st_reg        <= rbe_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
        cmd_reg       <= cmd_next;
        dq_reg        <= dq_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        out_byte_reg  <= out_byte_next;
        out_flush_reg <= out_flush_next;
        out_last_reg  <= out_last_next;
        out_err_reg   <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    always_comb begin
        m_tuser                      = '0;
        m_tuser[rbe_pkg::USER_FLUSH] = out_flush_reg;
        m_tuser[rbe_pkg::USER_ERR]   = out_err_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/rans_byte_encoder.sv
// An item is queued in the cycle it is accepted; the back end then pops it and
// its bytes leave from a registered output. The back end works on one item at a
// time: an encode item runs byte-serial renormalisation, the radix-16 divider
// and a fold step; a flush emits the whole coder state, an invalid symbol one
// error byte. A two-entry queue feeds the back end, so input is taken while it is busy.
// Reset (aresetn low, synchronous): coder state 2^23, prob_bits 12, all empty.
`default_nettype none

module rans_byte_encoder (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wen,
    input  wire logic [rbe_pkg::PB_W-1:0]           cfg_wdata,  // prob_bits
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [rbe_pkg::IN_TDATA_W-1:0]     s_tdata,    // sym_start, sym_freq, zero pad
    input  wire logic                               s_tuser,    // kind
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [rbe_pkg::BYTE_W-1:0]              m_tdata,    // out_byte
    output logic [rbe_pkg::OUT_TUSER_W-1:0]         m_tuser,    // is_flush, error
    output logic                                    m_tlast
);

    logic [rbe_pkg::PB_W-1:0] prob_bits_reg;
    logic [rbe_pkg::PB_W-1:0] pb;

    logic                     q_push;
    rbe_pkg::cmd_t            q_wdata;
    logic                     q_full;
    logic                     q_pop;
    rbe_pkg::cmd_t            q_rdata;
    logic                     q_not_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prob_bits_reg <= rbe_pkg::PB_RESET;
        end else if (cfg_wen) begin
            prob_bits_reg <= cfg_wdata;
        end
    end

    assign pb = rbe_pkg::clamp_pb(prob_bits_reg);

    rbe_front u_front (
        .pb       (pb),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_push   (q_push),
        .q_data   (q_wdata),
        .q_full   (q_full)
    );

    rbe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .not_empty (q_not_empty)
    );

    rbe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pb        (pb),
        .cmd_valid (q_not_empty),
        .cmd_in    (q_rdata),
        .cmd_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // an error result stands alone for its item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[rbe_pkg::USER_ERR] |-> m_tlast)
        else $error("error result not marked last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[rbe_pkg::USER_ERR] && m_tuser[rbe_pkg::USER_FLUSH]))
        else $error("flush byte flagged as error");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[rbe_pkg::USER_ERR] |-> m_tdata == '0)
        else $error("error result carries a non-zero byte");

endmodule

`default_nettype wire

FILE: sim/rbe_checker.sv
`timescale 1ns / 100ps

module rbe_checker
    import rbe_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wen,
    input  wire logic [PB_W-1:0]         cfg_wdata,
    input  wire logic                    s_tvalid,
    input  wire logic                    s_tready,
    input  wire logic [IN_TDATA_W-1:0]   s_tdata,    // sym_start, sym_freq, zero pad
    input  wire logic                    s_tuser,    // kind
    input  wire logic                    m_tvalid,
    input  wire logic                    m_tready,
    input  wire logic [BYTE_W-1:0]       m_tdata,    // out_byte
    input  wire logic [OUT_TUSER_W-1:0]  m_tuser,    // is_flush, error
    input  wire logic                    m_tlast,
    output int                           mismatches,
    output int                           pending
);

    typedef struct {
        logic [BYTE_W-1:0] code_byte;
        logic              is_flush;
        logic              last;
        logic              err;
    } code_byte_t;

    code_byte_t         code_bytes_due[$];
    logic [PB_W-1:0]    prob_bits;
    logic [STATE_W-1:0] coder_state;

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    task automatic report(input string what);
        mismatches++;
        if (mismatches <= 40) begin
            $display("ERROR at %0t: %0s", $time, what);
        end
    endtask

    task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic fl,
                              input logic lst, input logic er);
        code_byte_t c;
        c.code_byte = b;
        c.is_flush  = fl;
        c.last      = lst;
        c.err       = er;
        code_bytes_due.push_back(c);
    endtask

    // Work out the bytes one item produces and advance the coder state.
    task automatic fold_item(input logic kind, input logic [START_W-1:0] start,
                             input logic [FREQ_W-1:0] freq);
        int unsigned pbe;
        logic [63:0] total;
        logic [63:0] limit;
        logic [63:0] x;
        int          nbytes;
        pbe   = (prob_bits < PB_MIN) ? PB_MIN : (prob_bits > PB_MAX) ? PB_MAX : prob_bits;
        total = 64'd1 << pbe;
        if (kind == KIND_FLUSH) begin
            for (int i = 0; i < 4; i++) begin
                queue_byte(coder_state[STATE_W-1-BYTE_W*i -: BYTE_W], 1'b1, i == 3, 1'b0);
            end
            coder_state = STATE_RESET;
        end else if (freq == 0 || 64'(start) + 64'(freq) > total) begin
            // bad symbol: one error byte, state untouched
            queue_byte('0, 1'b0, 1'b1, 1'b1);
        end else begin
            limit  = ((64'd1 << STATE_LOW_EXP) >> pbe) << BYTE_W;
            limit  = limit * freq;
            x      = coder_state;
            nbytes = 0;
            while (x >= limit && nbytes < 4) begin
                queue_byte(x[BYTE_W-1:0], 1'b0, 1'b0, 1'b0);
                x = x >> BYTE_W;
                nbytes++;
                if (x < limit || nbytes == 4) begin
                    code_bytes_due[code_bytes_due.size()-1].last = 1'b1;
                end
            end
            x = ((x / freq) << pbe) + (x % freq) + start;
            coder_state = x[STATE_W-1:0];
        end
    endtask

    task automatic check_byte();
        code_byte_t want;
        if (code_bytes_due.size() == 0) begin
            report($sformatf("byte %02h with nothing outstanding", m_tdata));
        end else begin
            want = code_bytes_due.pop_front();
            if (m_tdata !== want.code_byte) begin
                report($sformatf("out_byte %02h, want %02h", m_tdata, want.code_byte));
            end
            if (m_tuser[USER_FLUSH] !== want.is_flush) begin
                report($sformatf("is_flush %b, want %b", m_tuser[USER_FLUSH], want.is_flush));
            end
            if (m_tuser[USER_ERR] !== want.err) begin
                report($sformatf("error %b, want %b", m_tuser[USER_ERR], want.err));
            end
            if (m_tlast !== want.last) begin
                report($sformatf("last %b, want %b", m_tlast, want.last));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            prob_bits   = PB_RESET;
            coder_state = STATE_RESET;
            code_bytes_due.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                fold_item(s_tuser, s_tdata[START_W-1:0], s_tdata[START_W +: FREQ_W]);
            end
            if (m_tvalid && m_tready) begin
                check_byte();
            end
            if (cfg_wen) begin
                prob_bits = cfg_wdata;
            end
        end
        pending = code_bytes_due.size();
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import rbe_pkg::*;

    localparam logic KIND_SYMBOL   = ~KIND_FLUSH;
    localparam int   HOLD_CYCLES   = 300;
    localparam int   SETTLE_CYCLES = 60;
    localparam int   CYCLE_LIMIT   = 400000;
    localparam int   PHASES        = 8;
    localparam int   PHASE_ITEMS   = 55;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wen   = 1'b0;
    logic [PB_W-1:0]        cfg_wdata = PB_RESET;
    logic                   s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tready  = 1'b0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [BYTE_W-1:0]      m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tlast;

    int              mismatches;
    int              pending;
    int              cycles     = 0;
    int              burst_left = 0;
    int              rx_mode    = 0;
    int              rx_tick    = 0;
    bit              hold_req   = 1'b0;
    logic [PB_W-1:0] prob_bits  = PB_RESET;
    logic [PB_W-1:0] scale_plan [PHASES] = '{5'd12, 5'd0, 5'd31, 5'd1, 5'd16, 5'd17, 5'd5, 5'd9};

    rans_byte_encoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    rbe_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: the stall pattern is drawn anew at random among four modes; a hold request
    // blocks the output for a long stretch.
    always begin
        @(negedge aclk);
        if (hold_req) begin
            hold_req = 1'b0;
            m_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge aclk);
        end else begin
            if (rx_tick % 48 == 0) begin
                rx_mode = $urandom_range(3);
            end
            rx_tick++;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(1));
                2:       m_tready <= ($urandom_range(7) == 0);
                default: m_tready <= (rx_tick % 6) < 2;
            endcase
        end
    end

    function automatic int unsigned eff_bits();
        return (prob_bits < PB_MIN) ? PB_MIN : (prob_bits > PB_MAX) ? PB_MAX : prob_bits;
    endfunction

    // Present one item, hold until taken, then either run on or drop into a gap.
    task automatic offer(input logic kind, input logic [START_W-1:0] start,
                         input logic [FREQ_W-1:0] freq);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= IN_TDATA_W'({freq, start});
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(negedge aclk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 20) : $urandom_range(8);
        end
    endtask

    // Drop valid and wait for every outstanding byte plus the back end's tail.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_scale(input logic [PB_W-1:0] v);
        settle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        prob_bits = v;
        @(negedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic send_symbol();
        int unsigned total;
        int unsigned freq;
        total = 1 << eff_bits();
        case ($urandom_range(3))
            0:       freq = 1;
            1:       freq = $urandom_range((total + 15) / 16, 1);
            2:       freq = $urandom_range(total, total / 2);
            default: freq = $urandom_range(total, 1);
        endcase
        offer(KIND_SYMBOL, START_W'($urandom_range(total - freq)), FREQ_W'(freq));
    endtask

    task automatic send_broken();
        int unsigned total;
        int unsigned freq;
        total = 1 << eff_bits();
        case ($urandom_range(2))
            0: offer(KIND_SYMBOL, START_W'($urandom), '0);
            1: begin
                // range one past the total
                freq = $urandom_range(total, 2);
                offer(KIND_SYMBOL, START_W'(total - freq + 1), FREQ_W'(freq));
            end
            default: offer(KIND_SYMBOL, START_W'($urandom),
                           FREQ_W'($urandom_range(131071, total + 1)));
        endcase
    endtask

    task automatic send_random();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5) begin
            offer(KIND_FLUSH, START_W'($urandom), FREQ_W'($urandom));
        end else if (r < 11) begin
            offer(1'($urandom_range(1)), START_W'($urandom), FREQ_W'($urandom));
        end else if (r < 17) begin
            send_broken();
        end else begin
            send_symbol();
        end
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // reset scale
        offer(KIND_FLUSH, '1, '1);
        offer(KIND_SYMBOL, 0, 2048);
        offer(KIND_SYMBOL, 0, 1);
        offer(KIND_SYMBOL, 4095, 1);
        offer(KIND_SYMBOL, 0, 4096);
        offer(KIND_SYMBOL, 0, 0);
        offer(KIND_SYMBOL, 4000, 97);
        offer(KIND_SYMBOL, '1, '1);
        offer(KIND_SYMBOL, 1, 1);
        offer(KIND_SYMBOL, 2, 1);
        offer(KIND_SYMBOL, 3, 1);
        offer(KIND_FLUSH, 0, 0);

        // scale below range, treated as one
        set_scale(5'd0);
        offer(KIND_SYMBOL, 1, 1);
        offer(KIND_SYMBOL, 0, 2);
        offer(KIND_SYMBOL, 1, 2);
        offer(KIND_FLUSH, 0, 0);

        // scale above range, treated as sixteen
        set_scale(5'd31);
        offer(KIND_SYMBOL, 65535, 1);
        offer(KIND_SYMBOL, 0, 65536);
        offer(KIND_SYMBOL, 32768, 32769);
        offer(KIND_FLUSH, 0, 0);

        for (int phase = 0; phase < PHASES; phase++) begin
            set_scale(scale_plan[phase]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (phase == 3 && k == 10) begin
                    // block the output and keep pushing so the input backs up
                    hold_req   = 1'b1;
                    burst_left = 30;
                end
                send_random();
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
